[rtl/rpms_pkg.sv]
package rpms_pkg;

  typedef enum logic [1:0] {
    STATUS_STEP  = 2'd0,
    STATUS_START = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DIR_LEFT     = 2'd0,
    DIR_RIGHT    = 2'd1,
    DIR_BACKWARD = 2'd2,
    DIR_FORWARD  = 2'd3
  } dir_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  localparam int CFG_W   = 7;
  localparam int COORD_W = 6;
  localparam int PICK_W  = 12;
  localparam int LEFT_W  = 13;

  typedef struct packed {
    logic                op;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic [PICK_W-1:0]   frontier_pick;
    logic [1:0]          neighbor_pick;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic [COORD_W-1:0]  neighbor_x;
    logic [COORD_W-1:0]  neighbor_y;
    dir_t                direction;
    logic [LEFT_W-1:0]   frontier_left;
    logic                done_res;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_PICK_RD,
    S_PICK_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_NB_RD,
    S_NB_WAIT,
    S_JOIN,
    S_Q_RD,
    S_Q_WAIT,
    S_Q_WR,
    S_OUT
  } state_t;

endpackage

[rtl/rpms_if.sv]
interface rpms_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rpms_ram.sv]
module rpms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/randomized_prim_maze_step.sv]
// Operation: start clears 2^(XW+YW) flag entries (4096 by default), one per cycle,
//   then joins the start cell and queues its neighbors; step: modulo, shift of the frontier
//   list, neighbor reads, join and queueing.
//   A step on an empty frontier goes straight to the output state.
// Throughput: one transaction at a time; the next is taken once the result is loaded into the output register.
// Reset: synchronous rst clears control and frontier count; the flag memory is
//   swept by each start. Grid size returns to 64 by 64.
module randomized_prim_maze_step
  import rpms_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  rpms_if.sink               in_ch,
  rpms_if.source             out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int DW    = (XW > YW) ? XW : YW;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [DW:0] eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(64);
      grid_height <= CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width == '0) eff_w = (DW+1)'(1);
    else if (32'(grid_width) > MAX_WIDTH) eff_w = (DW+1)'(MAX_WIDTH);
    else eff_w = (DW+1)'(grid_width);
    if (grid_height == '0) eff_h = (DW+1)'(1);
    else if (32'(grid_height) > MAX_HEIGHT) eff_h = (DW+1)'(MAX_HEIGHT);
    else eff_h = (DW+1)'(grid_height);
  end

  state_t state, state_next;
  in_item_t  item;
  out_item_t res;
  out_item_t res_out;
  logic      refuse;

  logic [CW-1:0] fcount;
  logic [AW-1:0] ptr;
  logic [CW-1:0] cnt;
  logic [PICK_W-1:0] rem;
  logic [3:0] mstep;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [2:0] qi;
  logic [3:0] nb_in;
  logic [2:0] nbi;

  // cell flags: {frontier, in}; cleared on start by a sweep
  logic          fl_we;
  logic [AW-1:0] fl_waddr, fl_raddr;
  logic [1:0]    fl_wdata, fl_rdata;
  rpms_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_flags (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata));

  logic          lst_we;
  logic [AW-1:0] lst_waddr, lst_raddr;
  logic [AW-1:0] lst_wdata, lst_rdata;
  rpms_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_list (
    .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata(lst_rdata));

  // neighbor probe: qi 0..3 = forward, backward, right, left (queue order)
  logic          nvalid;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  always_comb begin
    nvalid = 1'b0;
    nx = cx;
    ny = cy;
    case (qi[1:0])
      2'd0: begin
        nvalid = ({1'b0, cy} + 1'b1) < eff_h[YW:0];
        ny = cy + 1'b1;
      end
      2'd1: begin
        nvalid = cy != '0;
        ny = cy - 1'b1;
      end
      2'd2: begin
        nvalid = ({1'b0, cx} + 1'b1) < eff_w[XW:0];
        nx = cx + 1'b1;
      end
      default: begin
        nvalid = cx != '0;
        nx = cx - 1'b1;
      end
    endcase
  end

  logic [AW-1:0] naddr;
  assign naddr = AW'({ny, nx});

  // queueing needs the whole neighbor inside the current grid
  logic qvalid;
  assign qvalid = nvalid && ({1'b0, nx} < eff_w[XW:0]) && ({1'b0, ny} < eff_h[YW:0]);

  // modulo by restoring subtraction, one bit per cycle
  logic [PICK_W+CW-1:0] dsh;
  assign dsh = {{PICK_W{1'b0}}, fcount} << mstep;

  logic [2:0] ncount;
  logic [1:0] kpick;
  always_comb begin
    ncount = 3'(nb_in[0]) + 3'(nb_in[1]) + 3'(nb_in[2]) + 3'(nb_in[3]);
    kpick = '0;
    unique case (ncount)
      3'd2: kpick = {1'b0, item.neighbor_pick[0]};
      3'd3: kpick = (item.neighbor_pick == 2'd3) ? 2'd0 : item.neighbor_pick;
      3'd4: kpick = item.neighbor_pick;
      default: kpick = '0;
    endcase
  end

  // k-th set bit of nb_in (order left,right,backward,forward)
  logic [1:0] ksel;
  always_comb begin
    logic [2:0] seen;
    seen = '0;
    ksel = '0;
    for (int d = 0; d < 4; d++) begin
      if (nb_in[d]) begin
        if (seen == {1'b0, kpick}) ksel = 2'(d);
        seen = seen + 1'b1;
      end
    end
  end

  always_comb begin
    res_out = res;
    if (refuse) begin
      res_out.status = STATUS_EMPTY;
      res_out.done_res = 1'b1;
    end else begin
      res_out.frontier_left = LEFT_W'(fcount);
      res_out.done_res = (fcount == '0);
    end
  end

  always_comb begin
    state_next = state;
    fl_we = 1'b0; fl_waddr = ptr; fl_wdata = '0; fl_raddr = naddr;
    lst_we = 1'b0; lst_waddr = ptr; lst_wdata = lst_rdata; lst_raddr = ptr;
    unique case (state)
      S_IDLE: if (in_ch.valid) begin
        if (in_ch.data.op == OP_START) state_next = S_CLEAR;
        else if (fcount == '0) state_next = S_OUT;
        else state_next = S_MOD;
      end
      S_CLEAR: begin
        fl_we = 1'b1;
        if (ptr == '1) state_next = S_JOIN;
      end
      S_MOD: if (mstep == '0) state_next = S_PICK_RD;
      S_PICK_RD: begin
        lst_raddr = AW'(rem);
        state_next = S_PICK_WAIT;
      end
      S_PICK_WAIT: state_next = S_SHIFT_RD;
      S_SHIFT_RD: begin
        lst_raddr = ptr + 1'b1;
        if (CW'(ptr) + 1'b1 >= fcount) state_next = S_NB_RD;
        else state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        lst_we = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_NB_RD: state_next = S_NB_WAIT;
      S_NB_WAIT: if (qi == 3'd3) state_next = S_JOIN;
        else state_next = S_NB_RD;
      S_JOIN: begin
        fl_we = 1'b1;
        fl_waddr = AW'({cy, cx});
        fl_wdata = 2'b01;
        state_next = S_Q_RD;
      end
      S_Q_RD: if (qi == 3'd4) state_next = S_OUT;
        else if (qvalid) state_next = S_Q_WAIT;
      S_Q_WAIT: state_next = S_Q_WR;
      S_Q_WR: begin
        if (fl_rdata == '0) begin
          fl_we = 1'b1;
          fl_waddr = naddr;
          fl_wdata = 2'b10;
          lst_we = 1'b1;
          lst_waddr = AW'(fcount);
          lst_wdata = naddr;
        end
        state_next = S_Q_RD;
      end
      S_OUT: if (!out_ch.valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fcount <= '0;
      refuse <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          ptr <= '0;
          qi <= '0;
          nb_in <= '0;
          mstep <= 4'(PICK_W);
          rem <= in_ch.data.frontier_pick;
          res <= '0;
          refuse <= (in_ch.data.op == OP_STEP) && (fcount == '0);
          if (in_ch.data.op == OP_START) begin
            fcount <= '0;
            cx <= (32'(in_ch.data.start_x) >= 32'(eff_w)) ?
              XW'(eff_w - 1'b1) : XW'(in_ch.data.start_x);
            cy <= (32'(in_ch.data.start_y) >= 32'(eff_h)) ?
              YW'(eff_h - 1'b1) : YW'(in_ch.data.start_y);
          end
        end
        S_CLEAR: ptr <= ptr + 1'b1;
        S_MOD: begin
          if ({{CW{1'b0}}, rem} >= dsh) rem <= PICK_W'({{CW{1'b0}}, rem} - dsh);
          if (mstep != '0) mstep <= mstep - 1'b1;
        end
        S_PICK_RD: ptr <= AW'(rem);
        S_PICK_WAIT: begin
          cx <= lst_rdata[XW-1:0];
          cy <= lst_rdata[AW-1:XW];
        end
        S_SHIFT_RD: if (CW'(ptr) + 1'b1 >= fcount) fcount <= fcount - 1'b1;
        S_SHIFT_WR: ptr <= ptr + 1'b1;
        S_NB_WAIT: begin
          // qi 0 fwd->bit3, 1 back->bit2, 2 right->bit1, 3 left->bit0
          nb_in[2'd3 - qi[1:0]] <= nvalid && fl_rdata[0];
          qi <= qi + 1'b1;
        end
        S_JOIN: begin
          qi <= '0;
          res.cell_x <= COORD_W'(cx);
          res.cell_y <= COORD_W'(cy);
          if (item.op == OP_START) begin
            res.status <= STATUS_START;
          end else begin
            res.status <= STATUS_STEP;
            res.direction <= dir_t'(ksel);
            res.neighbor_x <= (ncount == '0) ? COORD_W'(cx) :
              (dir_t'(ksel) == DIR_LEFT) ? COORD_W'(cx - 1'b1) :
              (dir_t'(ksel) == DIR_RIGHT) ? COORD_W'(cx + 1'b1) : COORD_W'(cx);
            res.neighbor_y <= (ncount == '0) ? COORD_W'(cy) :
              (dir_t'(ksel) == DIR_BACKWARD) ? COORD_W'(cy - 1'b1) :
              (dir_t'(ksel) == DIR_FORWARD) ? COORD_W'(cy + 1'b1) : COORD_W'(cy);
          end
        end
        S_Q_RD: if (qi != 3'd4 && !qvalid) qi <= qi + 1'b1;
        S_Q_WR: begin
          if (fl_rdata == '0) fcount <= fcount + 1'b1;
          qi <= qi + 1'b1;
        end
        S_OUT: if (!out_ch.valid || out_ch.ready) out_ch.data <= res_out;
        default: ;
      endcase
    end
  end
endmodule
